[hw/rtl/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; imported by every module of the block.
package sem_pkg;

    localparam int COL_W  = 13;   // widest column index (line length up to 8192)
    localparam int ROW_W  = 12;
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 21;   // gx^2 + gy^2 <= 2 * 1020^2
    localparam int GRAD_W = 11;

    localparam logic REG_ROW_LENGTH   = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [10:0] ROW_LENGTH_RST   = 11'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam int          HEIGHT_LIMIT     = 4096;

    typedef enum logic {
        F_IDLE,
        F_RD
    } f_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAD,
        B_SQ,
        B_SUM,
        B_ROOT,
        B_EMIT
    } b_state_t;

    // One classified pixel: position, which results it causes, its window.
    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic                  emit_diag;   // pixel (r-1, c-1)
        logic                  emit_right;  // pixel (r-1, W-1)
        logic                  emit_last;   // pixel (r, c) on the last row
        logic                  interior;
        logic [8:0][PIX_W-1:0] win;         // index = row*3 + col
        logic [PIX_W-1:0]      pix;
    } sem_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sem_fifo_stat_t;

endpackage

[hw/rtl/sem_front.sv]
// Front end: accepts pixels, keeps line buffers, window and raster counters,
// and pushes one classified job per pixel. Depends on sem_pkg.
module sem_front #(
    parameter int MAX_ROW = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           pixel,
    input  logic [$clog2(MAX_ROW)-1:0] w_last,
    input  logic [11:0]          h_last,
    input  logic                 cfg_wr,
    output logic                 push,
    output sem_pkg::sem_job_t    push_job,
    input  sem_pkg::sem_fifo_stat_t fifo_stat
);
    import sem_pkg::*;

    localparam int CW = $clog2(MAX_ROW);

    f_state_t              state_reg, state_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [CW-1:0]         c_reg;
    logic [ROW_W-1:0]      r_reg;
    logic [PIX_W-1:0]      pix_reg;
    logic [8:0][PIX_W-1:0] win_reg, win_next;
    logic [15:0]           line_mem [MAX_ROW];
    logic [15:0]           rd_reg;
    logic                  accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (accept) state_next = F_RD;
            F_RD:   if (!fifo_stat.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            F_IDLE: in_ready = 1'b1;
            F_RD:   push = !fifo_stat.full;
            default: in_ready = 1'b0;
        endcase
    end

    // raster counters advance at accept and clear on a register write
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // window shifts one column; new right column from the line buffers and the new pixel
    always_comb
    begin
        win_next = win_reg;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]   = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = rd_reg[15:8];
        win_next[5] = rd_reg[7:0];
        win_next[8] = pix_reg;
    end

    always_comb
    begin
        push_job.row        = r_reg;
        push_job.col        = COL_W'(c_reg);
        push_job.emit_diag  = (r_reg != '0) && (c_reg != '0);
        push_job.emit_right = (r_reg != '0) && (c_reg == w_last);
        push_job.emit_last  = (r_reg == h_last);
        push_job.interior   = (r_reg >= ROW_W'(2)) && (c_reg >= CW'(2));
        push_job.win        = win_next;
        push_job.pix        = pix_reg;
    end

    // line buffer: [15:8] two rows up, [7:0] one row up
    always_ff @(posedge clk)
    begin
        if (push)
            line_mem[c_reg] <= {rd_reg[7:0], pix_reg};
        if (accept)
            rd_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pixel;
            c_reg   <= col_reg;
            r_reg   <= row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (push)
                win_reg <= win_next;
        end
    end

endmodule

[hw/rtl/sem_fifo.sv]
// Two-entry job queue between front and back end.
// Depends on sem_pkg.
module sem_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  sem_pkg::sem_job_t        push_job,
    input  logic                     pop,
    output sem_pkg::sem_job_t        pop_job,
    output sem_pkg::sem_fifo_stat_t  stat
);
    import sem_pkg::*;

    sem_job_t   entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign pop_job    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hw/rtl/sem_back.sv]
// Back end: gradients, squared magnitude, bit-serial square root, and
// emission of up to three results per job. Depends on sem_pkg.
module sem_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sem_pkg::sem_fifo_stat_t fifo_stat,
    input  sem_pkg::sem_job_t       pop_job,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [11:0]             out_row,
    output logic [9:0]              out_col,
    output logic [7:0]              edge_value,
    output logic                    last_of_run
);
    import sem_pkg::*;

    b_state_t                 state_reg, state_next;
    sem_job_t                 job_reg;
    logic [2:0]               pend_reg, pend_next;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SUM_W-2:0]         sqx_reg, sqy_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [7:0]               root_reg;
    logic [2:0]               bit_reg;
    logic                     out_valid_reg;
    logic [11:0]              out_row_reg;
    logic [9:0]               out_col_reg;
    logic [7:0]               out_val_reg;
    logic                     out_last_reg;

    logic                     load, sel_last;
    logic [2:0]               sel_mask;
    logic [11:0]              sel_row;
    logic [9:0]               sel_col;
    logic [7:0]               sel_val;
    logic [7:0]               trial;
    logic [15:0]              trial_sq;
    logic [9:0]               gx_pos, gx_neg, gy_pos, gy_neg;
    logic [8:0][7:0]          w;
    logic [2:0]               head_pend;

    assign w         = job_reg.win;
    assign head_pend = {pop_job.emit_last, pop_job.emit_right, pop_job.emit_diag};

    assign gx_pos = 10'(w[2]) + {1'b0, w[5], 1'b0} + 10'(w[8]);
    assign gx_neg = 10'(w[0]) + {1'b0, w[3], 1'b0} + 10'(w[6]);
    assign gy_pos = 10'(w[6]) + {1'b0, w[7], 1'b0} + 10'(w[8]);
    assign gy_neg = 10'(w[0]) + {1'b0, w[1], 1'b0} + 10'(w[2]);

    assign trial    = root_reg | (8'd1 << bit_reg);
    assign trial_sq = trial * trial;

    // pick the lowest pending result
    always_comb
    begin
        if (pend_reg[0])
        begin
            sel_mask = 3'b001;
            sel_row  = job_reg.row - 12'd1;
            sel_col  = 10'(job_reg.col - COL_W'(1));
            sel_val  = job_reg.interior ? root_reg : w[4];
        end
        else if (pend_reg[1])
        begin
            sel_mask = 3'b010;
            sel_row  = job_reg.row - 12'd1;
            sel_col  = 10'(job_reg.col);
            sel_val  = w[5];
        end
        else
        begin
            sel_mask = 3'b100;
            sel_row  = job_reg.row;
            sel_col  = 10'(job_reg.col);
            sel_val  = job_reg.pix;
        end
        sel_last = ((pend_reg & ~sel_mask) == 3'b000);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!fifo_stat.empty)
                begin
                    if (pop_job.emit_diag && pop_job.interior)
                        state_next = B_GRAD;
                    else if (head_pend != 3'b000)
                        state_next = B_EMIT;
                end
            B_GRAD: state_next = B_SQ;
            B_SQ:   state_next = B_SUM;
            B_SUM:  state_next = B_ROOT;
            B_ROOT: if (bit_reg == 3'd0 || sum_reg[SUM_W-1:16] != '0) state_next = B_EMIT;
            B_EMIT: if (load && sel_last) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        case (state_reg)
            B_IDLE: pop  = !fifo_stat.empty;
            B_EMIT: load = !out_valid_reg || out_ready;
            default: pop = 1'b0;
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (pop)
            pend_next = head_pend;
        else if (load)
            pend_next = pend_reg & ~sel_mask;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= pop_job;
        if (state_reg == B_GRAD)
        begin
            gx_reg <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
            gy_reg <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        end
        if (state_reg == B_SQ)
        begin
            // widen before squaring so the product keeps all its bits
            sqx_reg <= (SUM_W-1)'(SUM_W'(gx_reg) * SUM_W'(gx_reg));
            sqy_reg <= (SUM_W-1)'(SUM_W'(gy_reg) * SUM_W'(gy_reg));
        end
        if (state_reg == B_SUM)
            sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        if (load)
        begin
            out_row_reg  <= sel_row;
            out_col_reg  <= sel_col;
            out_val_reg  <= sel_val;
            out_last_reg <= sel_last;
        end
    end

    // root: one bit per cycle, MSB first; saturates when the sum is 2^16 or more
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pend_reg      <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (state_reg == B_SUM)
            begin
                root_reg <= '0;
                bit_reg  <= 3'd7;
            end
            else if (state_reg == B_ROOT)
            begin
                if (sum_reg[SUM_W-1:16] != '0)
                    root_reg <= 8'hff;
                else if ({5'd0, trial_sq} <= sum_reg)
                    root_reg <= trial;
                bit_reg <= bit_reg - 3'd1;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign edge_value  = out_val_reg;
    assign last_of_run = out_last_reg;

endmodule

[hw/rtl/sobel_edge_magnitude.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Depends on sem_pkg, sem_front, sem_fifo and sem_back.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_ready/pixel. Results leave on
//   out_valid/out_ready with out_row, out_col, edge_value and last_of_run;
//   an item causes zero to three results, and last_of_run marks the last one.
//   Results lag the input by one row; the last row is also emitted as it
//   arrives. Border pixels pass through, interior ones get
//   floor(sqrt(gx^2+gy^2)) saturated to 255.
//   APB registers: 0x0 row_length (11 bits), 0x4 image_height (13 bits).
//   A write restarts the frame at row 0, column 0; write only while idle.
// Flow:
//   The front takes a new pixel only after the last one's job is pushed (line
//   buffer read at accept, then write at push). The back pops one job, then
//   emits its results one by one; for an interior pixel it first computes
//   gradients, squares, sum and the 8-step root, so the rate in the image
//   interior is set by the bit-serial root.
// Reset: counters, window and queue clear, registers return to 640 x 480.
//   Line buffers are not cleared; unwritten entries are never emitted.
// Stall: out_ready low holds the output register; the back end stops, the
//   two-entry queue fills and then in_ready drops.
module sobel_edge_magnitude #(
    parameter int MAX_ROW = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] out_row,
    output logic [9:0]  out_col,
    output logic [7:0]  edge_value,
    output logic        last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sem_pkg::*;

    localparam int CW = $clog2(MAX_ROW);

    logic [10:0]    row_length_reg;
    logic [12:0]    image_height_reg;
    logic           cfg_wr;
    logic [CW-1:0]  w_last;
    logic [11:0]    h_last;
    logic           push, pop;
    sem_job_t       push_job, pop_job;
    sem_fifo_stat_t fifo_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register readback
    always_comb
    begin
        case (paddr[2])
            REG_ROW_LENGTH:   prdata = 32'(row_length_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // out-of-range settings saturate: width to 1..MAX_ROW, height to 1..4096
    always_comb
    begin
        if (row_length_reg == '0)
            w_last = '0;
        else if (int'(row_length_reg) > MAX_ROW)
            w_last = CW'(MAX_ROW - 1);
        else
            w_last = CW'(row_length_reg - 11'd1);

        if (image_height_reg == '0)
            h_last = '0;
        else if (int'(image_height_reg) > HEIGHT_LIMIT)
            h_last = 12'(HEIGHT_LIMIT - 1);
        else
            h_last = 12'(image_height_reg - 13'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg   <= ROW_LENGTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_ROW_LENGTH:   row_length_reg   <= pwdata[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[12:0];
                default:          row_length_reg   <= row_length_reg;
            endcase
        end
    end

    sem_front #(
        .MAX_ROW (MAX_ROW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .w_last    (w_last),
        .h_last    (h_last),
        .cfg_wr    (cfg_wr),
        .push      (push),
        .push_job  (push_job),
        .fifo_stat (fifo_stat)
    );

    sem_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (fifo_stat)
    );

    sem_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_stat   (fifo_stat),
        .pop_job     (pop_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .edge_value  (edge_value),
        .last_of_run (last_of_run)
    );

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fifo_stat.full))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && fifo_stat.empty))
        else $error("job popped from empty queue");

    // front holds one pixel at a time: busy the cycle after an accept
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("pixel accepted while front busy");

endmodule
